>>> design/sdcb_pkg.sv
`default_nettype none

package sdcb_pkg;

  localparam int SAMPLE_W        = 16;
  localparam int COEF_W          = 16;
  localparam int COEF_FRAC_BITS  = 15;
  localparam int STATE_WIDTH     = 40;
  localparam int STATE_FRAC_BITS = 16;

  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  // register index, taken from the word address bit
  localparam logic REG_POLE   = 1'b0;
  localparam logic REG_BYPASS = 1'b1;

endpackage

`default_nettype wire

>>> design/stereo_dc_blocking_filter.sv
`default_nettype none

// Channel   Dir  Handshake                    Payload
// in        in   in_valid_i / in_ready_o      sample_in_i, channel_i
// out       out  out_valid_o / out_ready_i    sample_out_o, channel_out_o
// config    in   psel, penable, pwrite        paddr, pwdata, prdata, pready
//
// One sample per cycle sustained while out_ready_i stays high; output valid
// once the sample has passed the input register, then the result register.
// The filter math (multiply, add, saturate, round) sits between the two
// registers; unless bypassed, channel state updates when the result reg loads.
// While a result waits, the input register takes one more transfer, then holds.
// Reset clears the channel state, the config registers and all valids.

module stereo_dc_blocking_filter #(
  parameter int COEF_FRAC_BITS  = sdcb_pkg::COEF_FRAC_BITS,
  parameter int STATE_WIDTH     = sdcb_pkg::STATE_WIDTH,
  parameter int STATE_FRAC_BITS = sdcb_pkg::STATE_FRAC_BITS
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic signed [sdcb_pkg::SAMPLE_W-1:0]  sample_in_i,
  input  logic                                  channel_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [sdcb_pkg::SAMPLE_W-1:0]  sample_out_o,
  output logic                                  channel_out_o,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [sdcb_pkg::APB_ADDR_W-1:0]       paddr,
  input  logic [sdcb_pkg::APB_DATA_W-1:0]       pwdata,
  output logic [sdcb_pkg::APB_DATA_W-1:0]       prdata,
  output logic                                  pready
);

  localparam int SW = sdcb_pkg::SAMPLE_W;
  localparam int CW = sdcb_pkg::COEF_W;
  localparam int DW = sdcb_pkg::APB_DATA_W;

  logic signed [CW-1:0]          coef_q;
  logic                          bypass_q;
  logic                          in_valid_q, in_valid_d;
  logic signed [SW-1:0]          x_q;
  logic                          ch_q;
  logic                          out_valid_q, out_valid_d;
  logic signed [SW-1:0]          out_sample_q, out_sample_d;
  logic                          out_ch_q;
  logic signed [SW-1:0]          xp_q [2];
  logic signed [STATE_WIDTH-1:0] yp_q [2];
  logic signed [STATE_WIDTH-1:0] y_new;
  logic signed [SW-1:0]          filt_sample;
  logic                          adv;
  logic                          cfg_wr;

  assign adv         = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !in_valid_q || adv;
  assign in_valid_d  = (in_valid_i && in_ready_o) || (in_valid_q && !adv);
  assign out_valid_d = adv || (out_valid_q && !out_ready_i);

  // config
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q   <= '0;
      bypass_q <= 1'b0;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        sdcb_pkg::REG_POLE:   coef_q   <= $signed(pwdata[CW-1:0]);
        sdcb_pkg::REG_BYPASS: bypass_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[1:0] == 2'b00) begin
      unique case (paddr[2])
        sdcb_pkg::REG_POLE:   prdata = {{(DW-CW){coef_q[CW-1]}}, coef_q};
        sdcb_pkg::REG_BYPASS: prdata = {{(DW-1){1'b0}}, bypass_q};
        default:              prdata = '0;
      endcase
    end
  end

  // datapath
  sdcb_filter #(
    .COEF_FRAC_BITS  (COEF_FRAC_BITS),
    .STATE_WIDTH     (STATE_WIDTH),
    .STATE_FRAC_BITS (STATE_FRAC_BITS)
  ) u_filter (
    .coef_i   (coef_q),
    .x_i      (x_q),
    .xp_i     (xp_q[ch_q]),
    .yp_i     (yp_q[ch_q]),
    .y_o      (y_new),
    .sample_o (filt_sample)
  );

  assign out_sample_d = bypass_q ? x_q : filt_sample;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      xp_q[0]     <= '0;
      xp_q[1]     <= '0;
      yp_q[0]     <= '0;
      yp_q[1]     <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (adv && !bypass_q) begin
        xp_q[ch_q] <= x_q;
        yp_q[ch_q] <= y_new;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      x_q  <= sample_in_i;
      ch_q <= channel_i;
    end
    if (adv) begin
      out_sample_q <= out_sample_d;
      out_ch_q     <= ch_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign sample_out_o  = out_sample_q;
  assign channel_out_o = out_ch_q;

  // checks
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_q |-> in_ready_o)
    else $error("input stage empty but not ready");

  a_no_take_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !adv |-> !in_ready_o)
    else $error("input stage overwritten while held");

  a_bypass_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bypass_q |=> $stable(yp_q[0]) && $stable(yp_q[1]) &&
                 $stable(xp_q[0]) && $stable(xp_q[1]))
    else $error("filter state changed in bypass");

  a_bypass_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && bypass_q |=> sample_out_o == $past(x_q))
    else $error("bypass sample mismatch");

  a_channel_tag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> out_valid_o && channel_out_o == $past(ch_q))
    else $error("channel tag lost");

endmodule

`default_nettype wire

>>> design/sdcb_filter.sv
`default_nettype none

module sdcb_filter #(
  parameter int COEF_FRAC_BITS  = sdcb_pkg::COEF_FRAC_BITS,
  parameter int STATE_WIDTH     = sdcb_pkg::STATE_WIDTH,
  parameter int STATE_FRAC_BITS = sdcb_pkg::STATE_FRAC_BITS
) (
  input  logic signed [sdcb_pkg::COEF_W-1:0]   coef_i,
  input  logic signed [sdcb_pkg::SAMPLE_W-1:0] x_i,
  input  logic signed [sdcb_pkg::SAMPLE_W-1:0] xp_i,
  input  logic signed [STATE_WIDTH-1:0]        yp_i,
  output logic signed [STATE_WIDTH-1:0]        y_o,
  output logic signed [sdcb_pkg::SAMPLE_W-1:0] sample_o
);

  localparam int CW    = sdcb_pkg::COEF_W;
  localparam int SW    = sdcb_pkg::SAMPLE_W;
  localparam int YH_W  = STATE_WIDTH - COEF_FRAC_BITS + 1;
  localparam int PH_W  = CW + YH_W;
  localparam int PL_W  = CW + COEF_FRAC_BITS + 1;
  localparam int DS_W  = SW + 2 + STATE_FRAC_BITS;
  localparam int M0    = (PH_W > STATE_WIDTH) ? PH_W : STATE_WIDTH;
  localparam int M1    = (M0 > DS_W) ? M0 : DS_W;
  localparam int M2    = (M1 > 64) ? M1 : 64;
  localparam int SUM_W = M2 + 2;
  localparam int CL_W  = ((STATE_WIDTH > SW + 1 + STATE_FRAC_BITS) ?
                          STATE_WIDTH : SW + 1 + STATE_FRAC_BITS) + 1;

  localparam logic signed [SUM_W-1:0] OVF_LIM =
    {{(SUM_W-63){1'b0}}, 1'b1, {62{1'b0}}};
  localparam logic signed [SUM_W-1:0] OVF_NLIM = -OVF_LIM;
  localparam logic signed [SUM_W-1:0] SMAX =
    {{(SUM_W-STATE_WIDTH+1){1'b0}}, {(STATE_WIDTH-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SMIN = ~SMAX;
  localparam logic signed [STATE_WIDTH-1:0] YMAX = SMAX[STATE_WIDTH-1:0];
  localparam logic signed [STATE_WIDTH-1:0] YMIN = SMIN[STATE_WIDTH-1:0];

  localparam logic signed [CL_W-1:0] CL_HI = CL_W'(32767) <<< STATE_FRAC_BITS;
  localparam logic signed [CL_W-1:0] CL_LO = CL_W'(-32768) <<< STATE_FRAC_BITS;
  localparam logic [CL_W-1:0] HALF = CL_W'((64'(1) << STATE_FRAC_BITS) >> 1);

  logic signed [YH_W-1:0]       yh;
  logic signed [COEF_FRAC_BITS:0] yl;
  logic signed [PH_W-1:0]       p_hi;
  logic signed [PL_W-1:0]       p_lo;
  logic signed [SUM_W-1:0]      p_hi_x;
  logic signed [SUM_W-1:0]      prod;
  logic signed [SW:0]           diff;
  logic signed [SUM_W-1:0]      sum;
  logic signed [CL_W-1:0]       yc;
  logic                         neg;
  logic [CL_W-1:0]              mag;
  logic [CL_W-1:0]              rnd;
  logic [SW-1:0]                q;

  assign yh     = YH_W'(yp_i >>> COEF_FRAC_BITS);
  assign yl     = $signed({1'b0, yp_i[COEF_FRAC_BITS-1:0]});
  assign p_hi   = PH_W'(coef_i) * PH_W'(yh);
  assign p_lo   = PL_W'(coef_i) * PL_W'(yl);
  assign p_hi_x = SUM_W'(p_hi);
  assign prod   = p_hi_x + SUM_W'(p_lo >>> COEF_FRAC_BITS);
  assign diff   = (SW+1)'(x_i) - (SW+1)'(xp_i);
  assign sum    = prod + (SUM_W'(diff) <<< STATE_FRAC_BITS);

  always_comb begin
    priority if (p_hi_x > OVF_LIM) begin
      y_o = YMAX;
    end else if (p_hi_x < OVF_NLIM) begin
      y_o = YMIN;
    end else if (sum > SMAX) begin
      y_o = YMAX;
    end else if (sum < SMIN) begin
      y_o = YMIN;
    end else begin
      y_o = sum[STATE_WIDTH-1:0];
    end
  end

  always_comb begin
    yc = CL_W'(y_o);
    if (yc > CL_HI) begin
      yc = CL_HI;
    end else if (yc < CL_LO) begin
      yc = CL_LO;
    end
  end

  // round half away from zero on the magnitude
  assign neg      = yc[CL_W-1];
  assign mag      = neg ? CL_W'(-yc) : CL_W'(yc);
  assign rnd      = mag + HALF;
  assign q        = SW'(rnd >> STATE_FRAC_BITS);
  assign sample_o = neg ? $signed(SW'(-q)) : $signed(q);

endmodule

`default_nettype wire
